// ===== src/i2cbm_pkg.sv =====
package i2cbm_pkg;

    localparam int unsigned TICKS_W     = 16;
    localparam logic [TICKS_W-1:0] TICKS_RESET = 16'd80;

    typedef enum logic [2:0] {
        OP_IDLE  = 3'd0,
        OP_START = 3'd1,
        OP_WRITE = 3'd2,
        OP_READ  = 3'd3,
        OP_STOP  = 3'd4
    } op_t;

    // input item, last field in the lowest bits
    typedef struct packed {
        logic       sda_level;
        logic       send_ack;
        logic [7:0] data_byte;
        logic [2:0] command;
    } cmd_t;

    // result item, last field in the lowest bits
    typedef struct packed {
        logic       nack_seen;
        logic [7:0] read_byte;
        logic       done_res;
        logic       busy_res;
        logic       sda_low;
        logic       scl_low;
    } result_t;

endpackage

// ===== src/i2cbm_seq.sv =====
module i2cbm_seq #(
    parameter int unsigned COUNTER_WIDTH = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              step_en,
    input  i2cbm_pkg::cmd_t                   item,
    input  logic [i2cbm_pkg::TICKS_W-1:0]     ticks,
    output i2cbm_pkg::result_t                res
);
    import i2cbm_pkg::*;

    localparam logic [32:0] CNT_MAX_W = (33'd1 << COUNTER_WIDTH) - 33'd1;
    localparam logic [31:0] CNT_MAX   = CNT_MAX_W[31:0];

    op_t                      op_reg, op_next;
    logic [4:0]               step_reg, step_next;
    logic [COUNTER_WIDTH-1:0] cnt_reg, cnt_next;
    logic [7:0]               shift_reg, shift_next;
    logic                     scl_reg, scl_next;
    logic                     sda_reg, sda_next;
    logic                     nack_reg, nack_next;
    logic                     ack_reg, ack_next;
    logic [7:0]               rd_reg, rd_next;

    logic                     exec;
    logic                     last;
    logic [TICKS_W-1:0]       ticks_m1;
    logic [31:0]              ticks_m1_w;
    logic [COUNTER_WIDTH-1:0] load;

    // zero acts as one tick; saturate to what the counter holds
    always_comb begin
        ticks_m1   = (ticks == '0) ? '0 : ticks - 1'b1;
        ticks_m1_w = 32'(ticks_m1);
        load = (ticks_m1_w > CNT_MAX) ? CNT_MAX[COUNTER_WIDTH-1:0]
                                      : ticks_m1_w[COUNTER_WIDTH-1:0];
    end

    always_comb begin
        op_next    = op_reg;
        step_next  = step_reg;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        nack_next  = nack_reg;
        ack_next   = ack_reg;
        rd_next    = rd_reg;
        exec       = 1'b0;
        last       = 1'b0;

        if (op_reg == OP_IDLE) begin
            if (item.command >= 3'(OP_START) && item.command <= 3'(OP_STOP)) begin
                op_next    = op_t'(item.command);
                step_next  = '0;
                shift_next = (item.command == 3'(OP_WRITE)) ? item.data_byte : 8'd0;
                if (item.command == 3'(OP_READ)) begin
                    ack_next = item.send_ack;
                end
                exec = 1'b1;
            end
        end else if (cnt_reg != '0) begin
            cnt_next = cnt_reg - 1'b1;
        end else begin
            step_next = step_reg + 5'd1;
            exec      = 1'b1;
        end

        if (exec) begin
            unique case (op_next)
                OP_START: begin
                    unique case (step_next)
                        5'd0:    sda_next = 1'b0;
                        5'd1:    scl_next = 1'b0;
                        5'd2:    sda_next = 1'b1;
                        default: begin
                            scl_next = 1'b1;
                            last     = 1'b1;
                        end
                    endcase
                end
                OP_STOP: begin
                    unique case (step_next)
                        5'd0:    sda_next = 1'b1;
                        5'd1:    scl_next = 1'b0;
                        default: begin
                            sda_next = 1'b0;
                            last     = 1'b1;
                        end
                    endcase
                end
                OP_WRITE: begin
                    priority if (step_next == 5'd18) begin
                        scl_next = 1'b1;
                        last     = 1'b1;
                    end else if (step_next[0]) begin
                        scl_next = 1'b0;
                        // acknowledge bit sampled while SCL is released
                        if (step_next == 5'd17) begin
                            nack_next = item.sda_level;
                        end
                    end else begin
                        if (step_next != 5'd0) begin
                            scl_next = 1'b1;
                        end
                        if (step_next == 5'd16) begin
                            sda_next = 1'b0;
                        end else begin
                            // the byte latched on the accepting tick drives bit 7 at once
                            sda_next   = ~shift_next[7];
                            shift_next = {shift_next[6:0], 1'b0};
                        end
                    end
                end
                OP_READ: begin
                    priority if (step_next == 5'd0) begin
                        sda_next = 1'b0;
                    end else if (step_next == 5'd18) begin
                        scl_next = 1'b1;
                        rd_next  = shift_reg;
                        last     = 1'b1;
                    end else if (step_next[0]) begin
                        scl_next = 1'b0;
                        if (step_next <= 5'd15) begin
                            shift_next = {shift_reg[6:0], item.sda_level};
                        end
                    end else begin
                        scl_next = 1'b1;
                        if (step_next == 5'd16) begin
                            sda_next = ack_reg;
                        end
                    end
                end
                default: last = 1'b1;
            endcase

            if (last) begin
                op_next   = OP_IDLE;
                step_next = '0;
                cnt_next  = '0;
            end else begin
                cnt_next = load;
            end
        end
    end

    always_comb begin
        res.scl_low   = scl_next;
        res.sda_low   = sda_next;
        res.busy_res  = (op_next != OP_IDLE);
        res.done_res  = exec & last;
        res.read_byte = rd_next;
        res.nack_seen = nack_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_reg    <= OP_IDLE;
            step_reg  <= '0;
            cnt_reg   <= '0;
            shift_reg <= '0;
            scl_reg   <= 1'b0;
            sda_reg   <= 1'b0;
            nack_reg  <= 1'b0;
            ack_reg   <= 1'b0;
            rd_reg    <= '0;
        end else if (step_en) begin
            op_reg    <= op_next;
            step_reg  <= step_next;
            cnt_reg   <= cnt_next;
            shift_reg <= shift_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
            nack_reg  <= nack_next;
            ack_reg   <= ack_next;
            rd_reg    <= rd_next;
        end
    end

endmodule

// ===== src/i2c_bit_level_master_top.sv =====
// Open-drain I2C bit engine advanced by one timebase tick per input transfer.
// Every accepted transfer produces exactly one result transfer showing the
// pin drives, busy, done, last read byte and last write's nack after that
// tick. One transfer is accepted per clock: the sequencer updates its state
// in the accepting cycle and the result lands in a single output register,
// so the input stalls only while that register holds an untaken result.
// A command (start, write, read, stop) is taken only while not busy; each
// pin step is held for cfg_data ticks (zero behaves as one). Configuration
// writes are accepted at any cycle and must be issued while idle.
module i2c_bit_level_master_top #(
    parameter int unsigned COUNTER_WIDTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // command[2:0], data_byte[10:3], send_ack[11], sda_level[12], zero[15:13]
    input  logic [15:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // scl_low[0], sda_low[1], busy_res[2], done_res[3], read_byte[11:4],
    // nack_seen[12], zero[15:13]
    output logic [15:0] m_axis_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);
    import i2cbm_pkg::*;

    logic [TICKS_W-1:0] ticks_reg;
    logic               out_valid_reg;
    result_t            out_reg;
    result_t            res;
    cmd_t               item;
    logic               s_xfer;

    assign item          = cmd_t'(s_axis_tdata[12:0]);
    assign s_axis_tready = ~out_valid_reg | m_axis_tready;
    assign s_xfer        = s_axis_tvalid & s_axis_tready;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_reg};

    i2cbm_seq #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (s_xfer),
        .item    (item),
        .ticks   (ticks_reg),
        .res     (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ticks_reg <= TICKS_RESET;
        end else if (cfg_valid) begin
            ticks_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s_xfer) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            out_reg <= res;
        end
    end

    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reg.done_res |-> !out_reg.busy_res)
        else $error("done reported while still busy");

    a_stall_only_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> out_valid_reg && !m_axis_tready)
        else $error("input stalled without a pending result");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |=> m_axis_tvalid)
        else $error("accepted tick produced no result");

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import i2cbm_pkg::*;

    localparam logic [2:0] CMD_MAX = 3'd7;

    localparam int SCL_BIT = 0;
    localparam int SDA_BIT = 1;

    // byte-transfer steps of write and read (the ack sample is write only)
    localparam logic [4:0] STEP_ACK_DRIVE  = 5'd16;
    localparam logic [4:0] STEP_ACK_SAMPLE = 5'd17;
    localparam logic [4:0] STEP_LAST       = 5'd18;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int MAX_REPORTS    = 10;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = '0;

    // sequencer mirror
    op_t                seq_op;
    logic [4:0]         seq_step;
    logic [TICKS_W-1:0] seq_wait;
    logic [7:0]         seq_shift;
    logic [1:0]         seq_pins;
    logic               seq_nack;
    logic               seq_ack;
    logic [7:0]         seq_read;
    logic [TICKS_W-1:0] seq_period;

    result_t pending_status_q[$];
    int      err_count = 0;
    int      quiet_cycles = 0;
    bit      idle_on = 1'b0;
    int      hold_left = 0;

    i2c_bit_level_master_top #(.COUNTER_WIDTH(16)) uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    task automatic reset_sequencer();
        seq_op     = OP_IDLE;
        seq_step   = '0;
        seq_wait   = '0;
        seq_shift  = '0;
        seq_pins   = '0;
        seq_nack   = 1'b0;
        seq_ack    = 1'b0;
        seq_read   = '0;
        seq_period = TICKS_RESET;
    endtask

    // One timebase tick: accept a command when idle, else count down or step.
    task automatic advance_sequencer(input cmd_t it, output result_t r);
        logic fire;
        logic last;
        fire = 1'b0;
        last = 1'b0;
        if (seq_op == OP_IDLE) begin
            if (it.command >= OP_START && it.command <= OP_STOP) begin
                seq_op = op_t'(it.command);
                seq_step = '0;
                seq_shift = (seq_op == OP_WRITE) ? it.data_byte : 8'h00;
                if (seq_op == OP_READ) seq_ack = it.send_ack;
                fire = 1'b1;
            end
        end else if (seq_wait != 0) begin
            seq_wait = seq_wait - 1'b1;
        end else begin
            seq_step = seq_step + 1'b1;
            fire = 1'b1;
        end

        if (fire) begin
            case (seq_op)
                OP_START: begin
                    case (seq_step)
                        5'd0: seq_pins[SDA_BIT] = 1'b0;
                        5'd1: seq_pins[SCL_BIT] = 1'b0;
                        5'd2: seq_pins[SDA_BIT] = 1'b1;
                        default: begin
                            seq_pins[SCL_BIT] = 1'b1;
                            last = 1'b1;
                        end
                    endcase
                end
                OP_STOP: begin
                    case (seq_step)
                        5'd0: seq_pins[SDA_BIT] = 1'b1;
                        5'd1: seq_pins[SCL_BIT] = 1'b0;
                        default: begin
                            seq_pins[SDA_BIT] = 1'b0;
                            last = 1'b1;
                        end
                    endcase
                end
                OP_WRITE: begin
                    if (seq_step == STEP_LAST) begin
                        seq_pins[SCL_BIT] = 1'b1;
                        last = 1'b1;
                    end else if (seq_step[0]) begin
                        seq_pins[SCL_BIT] = 1'b0;
                        if (seq_step == STEP_ACK_SAMPLE) seq_nack = it.sda_level;
                    end else begin
                        if (seq_step != 0) seq_pins[SCL_BIT] = 1'b1;
                        if (seq_step == STEP_ACK_DRIVE) begin
                            seq_pins[SDA_BIT] = 1'b0;
                        end else begin
                            seq_pins[SDA_BIT] = ~seq_shift[7];
                            seq_shift = {seq_shift[6:0], 1'b0};
                        end
                    end
                end
                OP_READ: begin
                    if (seq_step == 0) begin
                        seq_pins[SDA_BIT] = 1'b0;
                    end else if (seq_step == STEP_LAST) begin
                        seq_pins[SCL_BIT] = 1'b1;
                        seq_read = seq_shift;
                        last = 1'b1;
                    end else if (seq_step[0]) begin
                        seq_pins[SCL_BIT] = 1'b0;
                        if (seq_step < STEP_ACK_DRIVE)
                            seq_shift = {seq_shift[6:0], it.sda_level};
                    end else begin
                        seq_pins[SCL_BIT] = 1'b1;
                        if (seq_step == STEP_ACK_DRIVE) seq_pins[SDA_BIT] = seq_ack;
                    end
                end
                default: last = 1'b1;
            endcase

            if (last) begin
                seq_op = OP_IDLE;
                seq_step = '0;
                seq_wait = '0;
            end else begin
                // zero period runs as one tick per step
                seq_wait = (seq_period == 0) ? '0 : seq_period - 1'b1;
            end
        end

        r.scl_low   = seq_pins[SCL_BIT];
        r.sda_low   = seq_pins[SDA_BIT];
        r.busy_res  = (seq_op != OP_IDLE);
        r.done_res  = last;
        r.read_byte = seq_read;
        r.nack_seen = seq_nack;
    endtask

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        bit      moved;
        moved = 1'b0;
        if (!aresetn) begin
            reset_sequencer();
        end else begin
            if (cfg_valid && cfg_ready) begin
                seq_period = cfg_data;
                moved = 1'b1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                moved = 1'b1;
                got = m_axis_tdata[12:0];
                if (pending_status_q.size() == 0) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display("%0t: result transfer with nothing pending: %h",
                                 $realtime, got);
                end else begin
                    want = pending_status_q.pop_front();
                    if (got.scl_low !== want.scl_low || got.sda_low !== want.sda_low ||
                        got.busy_res !== want.busy_res ||
                        got.done_res !== want.done_res ||
                        got.read_byte !== want.read_byte ||
                        got.nack_seen !== want.nack_seen) begin
                        err_count++;
                        // scl, sda, busy, done, read byte, nack
                        if (err_count <= MAX_REPORTS)
                            $display("%0t: mismatch exp %b%b%b%b %h %b got %b%b%b%b %h %b",
                                     $realtime, want.scl_low, want.sda_low,
                                     want.busy_res, want.done_res, want.read_byte,
                                     want.nack_seen, got.scl_low, got.sda_low,
                                     got.busy_res, got.done_res, got.read_byte,
                                     got.nack_seen);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                moved = 1'b1;
                advance_sequencer(cmd_t'(s_axis_tdata[12:0]), want);
                pending_status_q.push_back(want);
            end
        end
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
    end

    function automatic int pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 80) return $urandom_range(1, 3);
        if (roll < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // result side back-pressure
    always @(negedge aclk) begin
        if (hold_left != 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 99) < 15) begin
            hold_left = pick_gap() - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_tick(input cmd_t it);
        int gap;
        gap = (idle_on && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, it};
        do @(posedge aclk); while (!s_axis_tready);
        @(negedge aclk);
    endtask

    function automatic cmd_t noise_tick();
        cmd_t t;
        t.command   = 3'($urandom_range(0, CMD_MAX));
        t.data_byte = 8'($urandom_range(0, 255));
        t.send_ack  = 1'($urandom_range(0, 1));
        t.sda_level = 1'($urandom_range(0, 1));
        return t;
    endfunction

    // Issue one command while idle, then tick until the sequence finishes.
    // Ticks sent while busy carry random commands, which must be ignored.
    task automatic run_command(input op_t op, input logic [7:0] dbyte, input logic ack);
        cmd_t t;
        t = noise_tick();
        t.command   = op;
        t.data_byte = dbyte;
        t.send_ack  = ack;
        send_tick(t);
        while (seq_op != OP_IDLE) send_tick(noise_tick());
    endtask

    task automatic send_ignored(input logic [2:0] code);
        cmd_t t;
        t = noise_tick();
        t.command = code;
        send_tick(t);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_status_q.size() != 0) @(negedge aclk);
    endtask

    task automatic write_period(input logic [15:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_period();
        idle_on = 1'b1;
        run_command(OP_STOP, 8'h00, 1'b0);
    endtask

    task automatic test_zero_period();
        write_period(16'd0);
        idle_on = 1'b1;
        run_command(OP_STOP, 8'h00, 1'b0);
        run_command(OP_WRITE, 8'h5A, 1'b0);
        run_command(OP_START, 8'h00, 1'b0);
        run_command(OP_WRITE, 8'hFF, 1'b0);
        run_command(OP_WRITE, 8'h00, 1'b1);
        run_command(OP_WRITE, 8'h80, 1'b0);
        run_command(OP_WRITE, 8'h01, 1'b1);
        run_command(OP_READ, 8'hFF, 1'b1);
        run_command(OP_READ, 8'h00, 1'b0);
        send_ignored(OP_IDLE);
        for (int c = OP_STOP + 1; c <= CMD_MAX; c++) send_ignored(c[2:0]);
        run_command(OP_STOP, 8'h00, 1'b0);
        run_command(OP_READ, 8'hA5, 1'b0);
    endtask

    task automatic random_frames(input int cmd_goal);
        int issued;
        int n_wr;
        int n_rd;
        logic ack;
        issued = 0;
        while (issued < cmd_goal) begin
            if ($urandom_range(0, 99) < 85) begin
                n_wr = $urandom_range(1, 2);
                n_rd = $urandom_range(0, 2);
                run_command(OP_START, 8'h00, 1'b0);
                for (int w = 0; w < n_wr; w++)
                    run_command(OP_WRITE, 8'($urandom_range(0, 255)),
                                1'($urandom_range(0, 1)));
                for (int k = 0; k < n_rd; k++) begin
                    // ack all but the last byte, with the odd policy violation
                    ack = (k != n_rd - 1);
                    if ($urandom_range(0, 9) == 0) ack = ~ack;
                    run_command(OP_READ, 8'($urandom_range(0, 255)), ack);
                end
                if ($urandom_range(0, 9) != 0) run_command(OP_STOP, 8'h00, 1'b0);
                issued += 2 + n_wr + n_rd;
            end else begin
                case ($urandom_range(0, 3))
                    0: send_ignored(3'($urandom_range(OP_STOP + 1, CMD_MAX)));
                    1: send_ignored(OP_IDLE);
                    2: run_command(op_t'($urandom_range(OP_START, OP_STOP)),
                                   8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                    default: run_command(OP_STOP, 8'h00, 1'b0);
                endcase
                issued++;
            end
        end
    endtask

    task automatic test_random_traffic();
        logic [15:0] periods[3];
        periods[0] = 16'd1;
        periods[1] = 16'd2;
        periods[2] = 16'($urandom_range(1, 3));
        foreach (periods[i]) begin
            write_period(periods[i]);
            idle_on = (i != 1);
            random_frames(3);
        end
    endtask

    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) @(posedge aclk);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        reset_sequencer();
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_reset_period();
        test_zero_period();
        test_random_traffic();

        wait_drained();
        idle_on = 1'b0;
        repeat (4) @(posedge aclk);
        if (err_count == 0 && pending_status_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== i2c_bit_level_master_top.f =====
src/i2cbm_pkg.sv
src/i2cbm_seq.sv
src/i2c_bit_level_master_top.sv
bench/tb_top.sv
